// ----- sv/aes128_reduced_round_encrypt_macros.svh -----
// assertion macros for the reduced-round aes-128 block
// used by the top level and the datapath
`ifndef AES128_REDUCED_ROUND_ENCRYPT_MACROS_SVH
`define AES128_REDUCED_ROUND_ENCRYPT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ----- sv/aes_pkg.sv -----
// shared constants and round functions for the reduced-round aes-128 block
// no dependencies
`default_nettype none
package aes_pkg;
  localparam int Rounds = 4;
  localparam int NumKeys = Rounds + 1;
  localparam int KeyIdxW = $clog2(NumKeys);
  localparam logic [0:0] RegKeyUpper = 1'b0;
  localparam logic [0:0] RegKeyLower = 1'b1;

  typedef logic [127:0] block_t;

  function automatic logic [7:0] sbox(input logic [7:0] a);
    logic [7:0] t [256];
    t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };
    return t[a];
  endfunction

  function automatic logic [7:0] rcon(input logic [3:0] i);
    logic [7:0] r;
    case (i)
      4'd0: r = 8'h01;
      4'd1: r = 8'h02;
      4'd2: r = 8'h04;
      4'd3: r = 8'h08;
      4'd4: r = 8'h10;
      4'd5: r = 8'h20;
      4'd6: r = 8'h40;
      4'd7: r = 8'h80;
      4'd8: r = 8'h1b;
      4'd9: r = 8'h36;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] mix_col(input logic [31:0] w);
    logic [7:0] a0, a1, a2, a3;
    a0 = w[31:24];
    a1 = w[23:16];
    a2 = w[15:8];
    a3 = w[7:0];
    return {xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3,
            a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3,
            a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3,
            xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3)};
  endfunction

  // one round: subbytes, shiftrows, optional mixcolumns, add key
  function automatic block_t aes_round(input block_t s, input block_t k, input logic last);
    logic [31:0] m [4];
    logic [31:0] t [4];
    block_t o;
    for (int c = 0; c < 4; c++) m[c] = sub_word(s[127 - 32*c -: 32]);
    for (int c = 0; c < 4; c++) begin
      t[c] = (m[c] & 32'hff000000) | (m[(c + 1) % 4] & 32'h00ff0000) |
             (m[(c + 2) % 4] & 32'h0000ff00) | (m[(c + 3) % 4] & 32'h000000ff);
      if (!last) t[c] = mix_col(t[c]);
    end
    o = {t[0], t[1], t[2], t[3]};
    return o ^ k;
  endfunction

  // next round key from the previous one
  function automatic block_t next_key(input block_t k, input logic [3:0] ri);
    logic [31:0] w0, w1, w2, w3, t;
    w3 = k[31:0];
    t = sub_word({w3[23:0], w3[31:24]}) ^ {rcon(ri), 24'h0};
    w0 = k[127:96] ^ t;
    w1 = k[95:64] ^ w0;
    w2 = k[63:32] ^ w1;
    w3 = w3 ^ w2;
    return {w0, w1, w2, w3};
  endfunction
endpackage
`default_nettype wire

// ----- sv/aes128_reduced_round_encrypt.sv -----
// Reduced-round AES-128 encryptor (4 rounds). One block is accepted per cycle;
// unless a key write, key rebuild or back-pressure stalls it. Whitening stage
// plus one register stage per round lead to the output register. After reset
// or a key write the round keys are rebuilt one per cycle, s_tready held low.
// depends on aes_pkg, aes_key_sched, aes_datapath and the macros header
`default_nettype none
`include "aes128_reduced_round_encrypt_macros.svh"
module aes128_reduced_round_encrypt (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cfg_we,
  input  wire logic [0:0] cfg_index,
  input  wire logic [63:0] cfg_data,
  input  wire logic s_tvalid,
  output logic s_tready,
  input  wire logic [127:0] s_tdata, // plain_upper, plain_lower
  output logic m_tvalid,
  input  wire logic m_tready,
  output logic [127:0] m_tdata // cipher_upper, cipher_lower
);
  logic [63:0] key_upper, key_lower;
  aes_pkg::block_t rk_table [aes_pkg::NumKeys];
  logic busy, dp_ready, cfg_hit;

  assign cfg_hit = cfg_we;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_upper <= '0;
      key_lower <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        aes_pkg::RegKeyUpper: key_upper <= cfg_data;
        aes_pkg::RegKeyLower: key_lower <= cfg_data;
        default: ;
      endcase
    end
  end

  aes_key_sched u_sched (
    .clk(clk), .rst(rst), .start(cfg_hit),
    .cipher_key({key_upper, key_lower}),
    .rk_table(rk_table), .busy(busy)
  );

  // fields swapped so plain_upper is tdata[63:0] per packing
  aes_datapath u_dp (
    .clk(clk), .rst(rst),
    .in_valid(s_tvalid && !busy && !cfg_we), .in_ready(dp_ready),
    .in_block({s_tdata[63:0], s_tdata[127:64]}),
    .rk_table(rk_table),
    .out_valid(m_tvalid), .out_ready(m_tready),
    .out_block({m_tdata[63:0], m_tdata[127:64]})
  );

  assign s_tready = dp_ready && !busy && !cfg_we;

  `ASSERT_IMPL(a_busy, clk, rst, busy, !s_tready)
  `ASSERT_NEXT(a_cfg, clk, rst, cfg_we, busy)
  `ASSERT_IMPL(a_acc, clk, rst, s_tvalid && s_tready, !busy)
endmodule
`default_nettype wire

// ----- sv/aes_key_sched.sv -----
// round key schedule: one round key expanded per cycle after reset or a key write
// depends on aes_pkg
`default_nettype none
module aes_key_sched (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  input  wire aes_pkg::block_t cipher_key,
  output aes_pkg::block_t rk_table [aes_pkg::NumKeys],
  output logic busy
);
  aes_pkg::block_t keys [aes_pkg::NumKeys];
  logic [aes_pkg::KeyIdxW-1:0] idx;

  assign rk_table = keys;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
      idx <= '0;
    end else if (start) begin
      busy <= 1'b1;
      idx <= '0;
    end else if (busy) begin
      if (idx == aes_pkg::KeyIdxW'(aes_pkg::Rounds)) busy <= 1'b0;
      else idx <= idx + 1'b1;
    end
  end

  // entry 0 is the key itself, each later entry comes from the one before
  always_ff @(posedge clk) begin
    keys[0] <= cipher_key;
    for (int r = 1; r < aes_pkg::NumKeys; r++)
      if (busy && idx == aes_pkg::KeyIdxW'(r))
        keys[r] <= aes_pkg::next_key(keys[r-1], 4'(r - 1));
  end
endmodule
`default_nettype wire

// ----- sv/aes_datapath.sv -----
// registered round pipeline: a whitening stage plus one stage per round, with stall
// depends on aes_pkg and the macros header
`default_nettype none
`include "aes128_reduced_round_encrypt_macros.svh"
module aes_datapath (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic in_ready,
  input  wire aes_pkg::block_t in_block,
  input  wire aes_pkg::block_t rk_table [aes_pkg::NumKeys],
  output logic out_valid,
  input  wire logic out_ready,
  output aes_pkg::block_t out_block
);
  aes_pkg::block_t st [aes_pkg::NumKeys];
  logic vld [aes_pkg::NumKeys];
  logic adv;

  assign adv = !vld[aes_pkg::Rounds] || out_ready;
  assign in_ready = adv;
  assign out_valid = vld[aes_pkg::Rounds];
  assign out_block = st[aes_pkg::Rounds];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < aes_pkg::NumKeys; i++) vld[i] <= 1'b0;
    end else if (adv) begin
      vld[0] <= in_valid;
      for (int i = 1; i < aes_pkg::NumKeys; i++) vld[i] <= vld[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st[0] <= in_block ^ rk_table[0];
      for (int i = 1; i < aes_pkg::NumKeys; i++)
        st[i] <= aes_pkg::aes_round(st[i-1], rk_table[i], i == aes_pkg::Rounds);
    end
  end

  `ASSERT_NEXT(a_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_block))
  `ASSERT_NEXT(a_adv, clk, rst, in_valid && in_ready, vld[0])
  `ASSERT_IMPL(a_rdy, clk, rst, !out_valid, in_ready)
endmodule
`default_nettype wire

// ----- tb/sv/aes128_round_checker.sv -----
// checker for the reduced-round aes-128 encryptor: tracks key writes, predicts
// each ciphertext from the accepted plaintext and compares it on the output stream
// depends on aes_pkg for the round count and register indexes
module aes128_round_checker (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         cfg_we,
  input  wire logic [0:0]   cfg_index,
  input  wire logic [63:0]  cfg_data,
  input  wire logic         s_tvalid,
  input  wire logic         s_tready,
  input  wire logic [127:0] s_tdata,
  input  wire logic         m_tvalid,
  input  wire logic         m_tready,
  input  wire logic [127:0] m_tdata,
  output int                fail_count,
  output int                pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [63:0] cipher_upper;
    logic [63:0] cipher_lower;
  } cipher_t;

  logic [7:0]   sub_table [256];
  logic [63:0]  key_hi, key_lo;
  logic [127:0] rk_table [0:aes_pkg::Rounds];
  cipher_t      cipher_q [$];

  function automatic logic [7:0] gf_double(input logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] p;
    p = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) p ^= a;
      a = gf_double(a);
    end
    return p;
  endfunction

  function automatic logic [31:0] sub_col(input logic [31:0] w);
    return {sub_table[w[31:24]], sub_table[w[23:16]], sub_table[w[15:8]], sub_table[w[7:0]]};
  endfunction

  // sbox built from the field inverse and the affine map
  initial begin
    logic [7:0] inv, s;
    for (int x = 0; x < 256; x++) begin
      inv = 8'h00;
      for (int y = 1; y < 256; y++)
        if (gf_mul(x[7:0], y[7:0]) == 8'h01) inv = y[7:0];
      s = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]}
          ^ {inv[3:0], inv[7:4]} ^ 8'h63;
      sub_table[x] = s;
    end
  end

  task automatic expand_round_keys();
    logic [31:0] w0, w1, w2, w3, t;
    logic [7:0]  rc;
    {w0, w1} = key_hi;
    {w2, w3} = key_lo;
    rc = 8'h01;
    rk_table[0] = {key_hi, key_lo};
    for (int r = 1; r <= aes_pkg::Rounds; r++) begin
      t = sub_col({w3[23:0], w3[31:24]}) ^ {rc, 24'h0};
      w0 ^= t;
      w1 ^= w0;
      w2 ^= w1;
      w3 ^= w2;
      rk_table[r] = {w0, w1, w2, w3};
      rc = gf_double(rc);
    end
  endtask

  function automatic cipher_t encrypt_block(input logic [127:0] plain);
    logic [31:0] m [4];
    logic [31:0] t [4];
    logic [7:0]  a0, a1, a2, a3;
    cipher_t     res;
    for (int c = 0; c < 4; c++)
      m[c] = plain[127 - 32*c -: 32] ^ rk_table[0][127 - 32*c -: 32];
    for (int r = 1; r <= aes_pkg::Rounds; r++) begin
      for (int c = 0; c < 4; c++) m[c] = sub_col(m[c]);
      for (int c = 0; c < 4; c++)
        t[c] = {m[c][31:24], m[(c + 1) % 4][23:16], m[(c + 2) % 4][15:8], m[(c + 3) % 4][7:0]};
      for (int c = 0; c < 4; c++) begin
        if (r != aes_pkg::Rounds) begin
          {a0, a1, a2, a3} = t[c];
          t[c] = {gf_mul(a0, 8'h02) ^ gf_mul(a1, 8'h03) ^ a2 ^ a3,
                  a0 ^ gf_mul(a1, 8'h02) ^ gf_mul(a2, 8'h03) ^ a3,
                  a0 ^ a1 ^ gf_mul(a2, 8'h02) ^ gf_mul(a3, 8'h03),
                  gf_mul(a0, 8'h03) ^ a1 ^ a2 ^ gf_mul(a3, 8'h02)};
        end
        m[c] = t[c] ^ rk_table[r][127 - 32*c -: 32];
      end
    end
    res.cipher_upper = {m[0], m[1]};
    res.cipher_lower = {m[2], m[3]};
    return res;
  endfunction

  always @(posedge clk) begin
    cipher_t want;
    if (rst) begin
      key_hi = '0;
      key_lo = '0;
      expand_round_keys();
      cipher_q.delete();
      fail_count = 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == aes_pkg::RegKeyUpper) key_hi = cfg_data;
        else key_lo = cfg_data;
        expand_round_keys();
      end
      if (m_tvalid && m_tready) begin
        if (cipher_q.size() == 0) begin
          $error("unexpected result %h", m_tdata);
          fail_count++;
        end else begin
          want = cipher_q.pop_front();
          if (m_tdata[63:0] !== want.cipher_upper) begin
            $error("cipher_upper expected %h actual %h", want.cipher_upper, m_tdata[63:0]);
            fail_count++;
          end
          if (m_tdata[127:64] !== want.cipher_lower) begin
            $error("cipher_lower expected %h actual %h", want.cipher_lower, m_tdata[127:64]);
            fail_count++;
          end
        end
      end
      if (s_tvalid && s_tready)
        cipher_q.push_back(encrypt_block({s_tdata[63:0], s_tdata[127:64]}));
    end
    pending = cipher_q.size();
  end
endmodule

// ----- tb/sv/tb_aes128_reduced_round_encrypt.sv -----
// top of the reduced-round aes-128 testbench: clock, reset, key writes and
// plaintext requests with random idling; needs aes_pkg, the block and aes128_round_checker
module tb_aes128_reduced_round_encrypt;
  timeunit 1ns;
  timeprecision 1ps;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         cfg_we = 1'b0;
  logic [0:0]   cfg_index = aes_pkg::RegKeyUpper;
  logic [63:0]  cfg_data = '0;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [127:0] s_tdata = '0; // plain_upper, plain_lower
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [127:0] m_tdata; // cipher_upper, cipher_lower
  logic         quiet = 1'b0;
  int           fail_count, pending;

  aes128_reduced_round_encrypt uut (.*);
  aes128_round_checker chk (.*);

  initial forever #1 clk = ~clk;

  initial begin
    #200us;
    $display("*** FAILED ***");
    $finish;
  end

  always @(negedge clk) m_tready <= quiet || $urandom_range(99) >= 11;

  function automatic logic [63:0] rand_word();
    case ($urandom_range(5))
      0: return '0;
      1: return '1;
      2: return {8{8'h80}} ^ {$urandom, $urandom} & {8{8'h01}};
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic send_plain(input logic [63:0] upper, input logic [63:0] lower);
    while (!quiet && $urandom_range(99) < 11) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata = {lower, upper};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_key(input logic [0:0] idx, input logic [63:0] value);
    s_tvalid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = value;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  initial begin
    repeat (2) @(negedge clk);
    rst = 1'b0;
    send_plain('0, '0);
    send_plain('1, '1);
    send_plain(64'h0011223344556677, 64'h8899aabbccddeeff);
    send_plain({8{8'h80}}, {8{8'h01}});
    for (int i = 0; i < 8; i++) send_plain(64'h1 << (i * 8 + 7), 64'h1 << (i * 8));
    write_key(aes_pkg::RegKeyUpper, '1);
    write_key(aes_pkg::RegKeyLower, '1);
    send_plain('0, '0);
    send_plain('1, '1);
    send_plain(64'h3243f6a8885a308d, 64'h313198a2e0370734);
    write_key(aes_pkg::RegKeyUpper, 64'h2b7e151628aed2a6);
    write_key(aes_pkg::RegKeyLower, 64'habf7158809cf4f3c);
    send_plain(64'h3243f6a8885a308d, 64'h313198a2e0370734);
    send_plain('0, '1);
    write_key(aes_pkg::RegKeyLower, '0);
    send_plain('1, '0);
    for (int phase = 0; phase < 7; phase++) begin
      if (phase == 6) begin
        write_key(aes_pkg::RegKeyUpper, '0);
        write_key(aes_pkg::RegKeyLower, '0);
      end else begin
        if (phase != 2) write_key(aes_pkg::RegKeyUpper, rand_word());
        write_key(aes_pkg::RegKeyLower, rand_word());
      end
      quiet = (phase == 3);
      for (int i = 0; i < 200; i++) send_plain(rand_word(), rand_word());
    end
    s_tvalid = 1'b0;
    quiet = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
